@@ hdl/fltu_pkg.sv @@
// fltu_pkg: shared types and constants for the first-line title extractor.
// Used by fltu_ctrl, fltu_dp and first_line_title_utf8_cap. No dependencies.

package fltu_pkg;

   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [9:0] MAX_CHARS_RESET = 10'd64;

   // line phase of the text being read
   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_EMIT = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH_RD,
      ST_FLUSH_PUT,
      ST_BYTE,
      ST_TAIL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;    // take the input item and update line state
      logic rd;        // read held byte at flush index
      logic put_held;  // offer the read held byte to the cap logic
      logic put_byte;  // offer the item byte to the cap logic
      logic finish;    // emit end marker if pending, clear state on last byte
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic flush_go;    // item needs held whitespace flushed (from input)
      logic byte_go;     // item byte goes to the cap logic (from input)
      logic tail_go;     // end marker or clear needed (from input)
      logic tail_pend;   // registered tail_go of the current item
      logic flush_last;  // flush index is on the last held byte
      logic slot_free;   // output register can take a result this cycle
   } dp_status_type;

endpackage

@@ hdl/fltu_ctrl.sv @@
// fltu_ctrl: sequencer for the title extractor.
// Depends on fltu_pkg; drives fltu_dp through dp_cmd_type.

module fltu_ctrl import fltu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.flush_go)      state_in = ST_FLUSH_RD;
               else if (status.byte_go)  state_in = ST_BYTE;
               else if (status.tail_go)  state_in = ST_TAIL;
            end
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_PUT;
         end
         ST_FLUSH_PUT: begin
            if (status.slot_free) begin
               state_in = status.flush_last ? ST_BYTE : ST_FLUSH_RD;
            end
         end
         ST_BYTE: begin
            if (status.slot_free) begin
               state_in = status.tail_pend ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_FLUSH_RD: begin
            cmd.rd = 1'b1;
         end
         ST_FLUSH_PUT: begin
            cmd.put_held = status.slot_free;
         end
         ST_BYTE: begin
            cmd.put_byte = status.slot_free;
         end
         ST_TAIL: begin
            cmd.finish = status.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ hdl/fltu_dp.sv @@
// fltu_dp: datapath of the title extractor: line state, whitespace hold
// memory, UTF-8 character cap and result register. Depends on fltu_pkg.

module fltu_dp import fltu_pkg::*; #(
   parameter int HOLD_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [9:0]    csr_wr_data,
   input  logic [7:0]    req_data_byte,
   input  logic          req_is_last,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_title_byte,
   output logic          rsp_has_byte,
   output logic          rsp_title_end
);

   localparam int CW = $clog2(HOLD_DEPTH + 1);
   localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

   // continuation bytes owed after a lead byte
   function automatic logic [1:0] seq_extra(input logic [7:0] b);
      logic [1:0] r;
      r = 2'd0;
      if (b < 8'h80)               r = 2'd0;
      else if (b[7:5] == 3'h6)     r = 2'd1;
      else if (b[7:4] == 4'hE)     r = 2'd2;
      else if (b[7:3] == 5'h1E)    r = 2'd3;
      return r;
   endfunction

   phase_type      phase_ff, phase_in;
   logic           fmt_ff, fmt_in;
   logic [9:0]     char_count_ff, char_count_in;
   logic [1:0]     cont_ff, cont_in;
   logic [CW-1:0]  held_count_ff, held_count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [9:0]     max_chars_ff;
   logic [7:0]     byte_ff;
   logic           last_ff;
   logic           end_pend_ff;
   logic           tail_pend_ff;
   logic [7:0]     rd_data_ff;
   logic [7:0]     hold_mem [HOLD_DEPTH];

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_has_ff;
   logic           rsp_end_ff;

   // item evaluation
   logic           is_lf, is_blank, is_trim;
   logic           ev_flush, ev_byte, ev_hold, ev_lf_end, ev_clr_held, ev_end;
   phase_type      ev_phase;
   logic           ev_fmt;

   always_comb begin
      is_lf    = (req_data_byte == BYTE_LF);
      is_blank = (req_data_byte == BYTE_SPACE) || (req_data_byte == BYTE_TAB) ||
                 (req_data_byte == BYTE_CR);
      is_trim  = req_data_byte inside {[BYTE_TAB:BYTE_CR], BYTE_SPACE};
      ev_flush    = 1'b0;
      ev_byte     = 1'b0;
      ev_hold     = 1'b0;
      ev_lf_end   = 1'b0;
      ev_clr_held = 1'b0;
      ev_phase    = phase_ff;
      ev_fmt      = fmt_ff;
      case (phase_ff)
         PH_SEEK: begin
            if (is_lf) begin
               if (fmt_ff) begin
                  ev_lf_end = 1'b1;
                  ev_phase  = PH_DONE;
               end
            end else if (is_blank) begin
               ev_fmt = fmt_ff;
            end else if (is_trim) begin
               ev_fmt = 1'b1;   // VT or FF makes the line content
            end else begin
               ev_phase = PH_EMIT;
               ev_byte  = 1'b1;
            end
         end
         PH_EMIT: begin
            if (is_lf) begin
               ev_lf_end   = 1'b1;
               ev_phase    = PH_DONE;
               ev_clr_held = 1'b1;
            end else if (is_trim) begin
               ev_hold = (held_count_ff < CW'(HOLD_DEPTH));
            end else begin
               ev_flush = (held_count_ff != '0);
               ev_byte  = 1'b1;
            end
         end
         default: begin
            ev_phase = phase_ff;   // title closed: ignore until last byte
         end
      endcase
      ev_end = ev_lf_end ||
               (req_is_last && ((ev_phase == PH_SEEK) || (ev_phase == PH_EMIT)));
   end

   // character cap
   logic [7:0] cap_byte;
   logic       cap_put;
   logic       cap_emit;
   logic [9:0] cap_count;
   logic [1:0] cap_cont;

   always_comb begin
      cap_byte  = cmd.put_held ? rd_data_ff : byte_ff;
      cap_put   = cmd.put_held || cmd.put_byte;
      cap_emit  = 1'b0;
      cap_count = char_count_ff;
      cap_cont  = cont_ff;
      if (cont_ff != 2'd0) begin
         cap_emit = 1'b1;
         cap_cont = cont_ff - 2'd1;
      end else if (char_count_ff < max_chars_ff) begin
         cap_emit  = 1'b1;
         cap_count = char_count_ff + 10'd1;
         cap_cont  = seq_extra(cap_byte);
      end
   end

   logic slot_free;
   logic rsp_load;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (cap_put && cap_emit) || (cmd.finish && end_pend_ff);

   // next state of line registers
   always_comb begin
      phase_in      = phase_ff;
      fmt_in        = fmt_ff;
      char_count_in = char_count_ff;
      cont_in       = cont_ff;
      held_count_in = held_count_ff;
      idx_in        = idx_ff;
      if (cmd.accept) begin
         phase_in = ev_phase;
         fmt_in   = ev_fmt;
         if (ev_hold)     held_count_in = held_count_ff + CW'(1);
         if (ev_clr_held) held_count_in = '0;
         idx_in = '0;
      end
      if (cap_put) begin
         char_count_in = cap_count;
         cont_in       = cap_cont;
      end
      if (cmd.put_held) begin
         if (status.flush_last) begin
            idx_in        = '0;
            held_count_in = '0;
         end else begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (cmd.finish && last_ff) begin
         phase_in      = PH_SEEK;
         fmt_in        = 1'b0;
         char_count_in = '0;
         cont_in       = '0;
         held_count_in = '0;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEEK;
         fmt_ff        <= 1'b0;
         char_count_ff <= '0;
         cont_ff       <= '0;
         held_count_ff <= '0;
         idx_ff        <= '0;
         max_chars_ff  <= MAX_CHARS_RESET;
         rsp_valid_ff  <= 1'b0;
         tail_pend_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         fmt_ff        <= fmt_in;
         char_count_ff <= char_count_in;
         cont_ff       <= cont_in;
         held_count_ff <= held_count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en)  max_chars_ff <= csr_wr_data;
         if (cmd.accept) tail_pend_ff <= ev_end || req_is_last;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff     <= req_data_byte;
         last_ff     <= req_is_last;
         end_pend_ff <= ev_end;
      end
      if (rsp_load) begin
         rsp_byte_ff <= cmd.finish ? 8'h00 : cap_byte;
         rsp_has_ff  <= !cmd.finish;
         rsp_end_ff  <= cmd.finish;
      end
   end

   // whitespace hold memory
   always_ff @(posedge clock) begin
      if (cmd.accept && ev_hold) hold_mem[held_count_ff[AW-1:0]] <= req_data_byte;
      if (cmd.rd)                rd_data_ff <= hold_mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      status            = '0;
      status.flush_go   = ev_flush;
      status.byte_go    = ev_byte;
      status.tail_go    = ev_end || req_is_last;
      status.tail_pend  = tail_pend_ff;
      status.flush_last = ((idx_ff + CW'(1)) == held_count_ff);
      status.slot_free  = slot_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_title_byte = rsp_byte_ff;
   assign rsp_has_byte   = rsp_has_ff;
   assign rsp_title_end  = rsp_end_ff;

endmodule

@@ hdl/first_line_title_utf8_cap.sv @@
// first_line_title_utf8_cap: top level of the first-line title extractor.
// Depends on fltu_pkg; instantiates fltu_ctrl and fltu_dp.
//
//   channel  dir  handshake         payload
//   req      in   req_valid/stall   req_data_byte[7:0], req_is_last
//   rsp      out  rsp_valid/stall   rsp_title_byte[7:0], rsp_has_byte, rsp_title_end
//   csr      in   csr_wr_en         csr_wr_data[9:0] (max_chars)
//
// An item that neither reaches the cap nor ends a line or text is taken in ST_IDLE
// alone; one that offers its own byte to the cap then passes ST_BYTE, and ending the
// title or the text adds ST_TAIL. Flushing N held whitespace bytes adds one memory
// read (ST_FLUSH_RD) and one cap step (ST_FLUSH_PUT) per held byte from the hold memory.
// A result stall holds the sequencer in its state while the output register is full.
// Reset is synchronous; it clears line state and sets max_chars to 64.

module first_line_title_utf8_cap import fltu_pkg::*; #(
   parameter int HOLD_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_title_byte,
   output logic       rsp_has_byte,
   output logic       rsp_title_end
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: accept, flush held whitespace, item byte, end marker
   fltu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // line state, hold memory, character cap and output register
   fltu_dp #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_data_byte  (req_data_byte),
      .req_is_last    (req_is_last),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_title_byte (rsp_title_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_title_end  (rsp_title_end)
   );

endmodule
